@@ hdl/gcfs_pkg.sv @@
// Package for the grounded cell fraction stencil unit.
// Holds widths, the cell record passed from front to back, and reset values.
// No dependencies.
`default_nettype none
package gcfs_pkg;
  localparam int FracBitsDef = 16;
  localparam int RatioW = 17;
  localparam int ElevW = 24;
  localparam int ThickW = 23;
  localparam int FlotW = 32;
  localparam int SubW = 36;
  localparam int OutW = 17;
  localparam logic [RatioW-1:0] RatioReset = 17'd58368;
  localparam int QDepth = 2;

  // nine sub-cell values, at four times their size
  typedef struct packed {
    logic signed [SubW-1:0] o;
    logic signed [SubW-1:0] n;
    logic signed [SubW-1:0] s;
    logic signed [SubW-1:0] w;
    logic signed [SubW-1:0] e;
    logic signed [SubW-1:0] nw;
    logic signed [SubW-1:0] ne;
    logic signed [SubW-1:0] sw;
    logic signed [SubW-1:0] se;
  } cell_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SEL, BK_MUL, BK_DIV, BK_ACC, BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

@@ hdl/gcfs_front.sv @@
// Front end: flotation values, column window, sub-cell values.
// Depends on gcfs_pkg.
`default_nettype none
module gcfs_front
  import gcfs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [RatioW-1:0]        ratio,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [ElevW-1:0]  sea_n, bed_n, sea_m, bed_m, sea_s, bed_s,
  input  wire logic [ThickW-1:0]        th_n, th_m, th_s,
  input  wire logic                     row_start,
  output logic                          c_valid,
  input  wire logic                     c_ready,
  output cell_t                         c_data
);
  // stage 1 registers: products and water depths
  logic                     s1_v_r, s1_v_nxt;
  logic [ThickW+RatioW-1:0] pn_r, pm_r, ps_r;
  logic signed [ElevW:0]    wn_r, wm_r, ws_r;
  logic                     s1_rs_r;
  logic signed [FlotW-1:0]  win_r [6];
  logic [1:0]               held_r;
  logic                     adv;

  assign adv = s1_v_r && (c_ready || !(held_r == 2'd2 && !s1_rs_r));
  assign in_stall = s1_v_r && !adv;
  assign s1_v_nxt = (in_valid && !in_stall) ? 1'b1 : (adv ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= s1_v_nxt;
    if (in_valid && !in_stall) begin
      pn_r <= th_n * ratio;
      pm_r <= th_m * ratio;
      ps_r <= th_s * ratio;
      wn_r <= {sea_n[ElevW-1], sea_n} - {bed_n[ElevW-1], bed_n};
      wm_r <= {sea_m[ElevW-1], sea_m} - {bed_m[ElevW-1], bed_m};
      ws_r <= {sea_s[ElevW-1], sea_s} - {bed_s[ElevW-1], bed_s};
      s1_rs_r <= row_start;
    end
  end

  // flotation values of the current column
  function automatic logic signed [FlotW-1:0] flot(
      input logic [ThickW+RatioW-1:0] p, input logic signed [ElevW:0] w);
    logic [ThickW+RatioW-1:0] t;
    t = (p + 40'd32768) >> 16;
    return FlotW'($signed({1'b0, t[FlotW-2:0]})) - FlotW'(w);
  endfunction

  logic signed [FlotW-1:0] en, ec, es;
  assign en = flot(pn_r, wn_r);
  assign ec = flot(pm_r, wm_r);
  assign es = flot(ps_r, ws_r);

  // window after an optional row clear
  logic signed [SubW-1:0] wn, wc, ws, mn, mc, ms, xn, xc, xs;
  always_comb begin
    wn = SubW'(win_r[0]); wc = SubW'(win_r[1]); ws = SubW'(win_r[2]);
    mn = SubW'(win_r[3]); mc = SubW'(win_r[4]); ms = SubW'(win_r[5]);
    xn = SubW'(en); xc = SubW'(ec); xs = SubW'(es);
    c_data.o  = mc <<< 2;
    c_data.n  = (mc + mn) <<< 1;
    c_data.s  = (mc + ms) <<< 1;
    c_data.w  = (mc + wc) <<< 1;
    c_data.e  = (mc + xc) <<< 1;
    c_data.nw = wn + wc + mn + mc;
    c_data.ne = mn + mc + xn + xc;
    c_data.sw = wc + ws + mc + ms;
    c_data.se = mc + ms + xc + xs;
  end
  assign c_valid = s1_v_r && held_r == 2'd2 && !s1_rs_r;

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (adv) begin
      win_r[0] <= s1_rs_r ? '0 : win_r[3];
      win_r[1] <= s1_rs_r ? '0 : win_r[4];
      win_r[2] <= s1_rs_r ? '0 : win_r[5];
      win_r[3] <= en; win_r[4] <= ec; win_r[5] <= es;
      held_r <= s1_rs_r ? 2'd1 : (held_r == 2'd2 ? 2'd2 : held_r + 2'd1);
    end
  end
endmodule
`default_nettype wire

@@ hdl/gcfs_queue.sv @@
// Short cell queue between front and back end.
// Depends on gcfs_pkg.
`default_nettype none
module gcfs_queue
  import gcfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  cell_t      wr_data,
  output logic       rd_valid,
  input  wire logic  rd_take,
  output cell_t      rd_data
);
  cell_t     mem_r [QDepth];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  assign wr_ready = cnt_r != 2'(QDepth);
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_take && rd_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_take && rd_valid);
    end
  end
endmodule
`default_nettype wire

@@ hdl/gcfs_back.sv @@
// Back end: eight triangle fractions through one shared radix-2 divider.
// Depends on gcfs_pkg.
`default_nettype none
module gcfs_back
  import gcfs_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
)(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_take,
  input  cell_t                  q_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [OutW-1:0]        out_fraction
);
  localparam int QW = FRAC_BITS + 2;
  localparam int SW = FRAC_BITS + 5;
  // flotation stays below 2^25, sub-cell values below 2^27, differences below 2^28
  localparam int MW = 30;
  localparam logic [QW-1:0] One = QW'(1) << FRAC_BITS;

  bk_state_t st_r, st_nxt;
  cell_t     c_r;
  logic [2:0] tri_r;
  logic [$clog2(FRAC_BITS+2)-1:0] it_r;
  logic [SW-1:0] sum_r;
  logic signed [SubW-1:0] v_r, p_r, q_r;
  logic vpos_r;
  logic [2*MW-1:0] n_r, d_r, rem_r;
  logic [QW-1:0] quo_r, tf_r;
  logic [OutW-1:0] res_r;

  // triangle vertices for this index
  logic signed [SubW-1:0] ta, tb, tc;
  always_comb begin
    ta = c_r.o;
    case (tri_r)
      3'd0: begin tb = c_r.ne; tc = c_r.n;  end
      3'd1: begin tb = c_r.n;  tc = c_r.nw; end
      3'd2: begin tb = c_r.nw; tc = c_r.w;  end
      3'd3: begin tb = c_r.w;  tc = c_r.sw; end
      3'd4: begin tb = c_r.sw; tc = c_r.s;  end
      3'd5: begin tb = c_r.s;  tc = c_r.se; end
      3'd6: begin tb = c_r.se; tc = c_r.e;  end
      default: begin tb = c_r.e; tc = c_r.ne; end
    endcase
  end
  logic pa, pb, pc;
  logic [1:0] cnt;
  assign pa = ta > 0;
  assign pb = tb > 0;
  assign pc = tc > 0;
  assign cnt = 2'(pa) + 2'(pb) + 2'(pc);

  function automatic logic [MW-1:0] mg(input logic signed [MW-1:0] x);
    return x[MW-1] ? MW'(-x) : MW'(x);
  endfunction
  logic [MW-1:0] mv, mvp, mvq;
  assign mv = mg(MW'(v_r));
  assign mvp = mg(MW'(v_r) - MW'(p_r));
  assign mvq = mg(MW'(v_r) - MW'(q_r));

  logic [2*MW:0] rsh;
  assign rsh = {rem_r, 1'b0};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (q_valid) st_nxt = BK_SEL;
      BK_SEL:  if (cnt != 2'd3 && cnt != 2'd0) st_nxt = BK_MUL;
               else if (tri_r == 3'd7) st_nxt = BK_ACC;
      BK_MUL:  st_nxt = BK_DIV;
      BK_DIV:  if (d_r == '0 || n_r >= d_r || it_r == '0) st_nxt = BK_ACC;
      BK_ACC:  st_nxt = (tri_r == 3'd7) ? BK_OUT : BK_SEL;
      BK_OUT:  if (!out_stall) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  assign q_take = st_r == BK_IDLE;
  assign out_valid = st_r == BK_OUT;
  assign out_fraction = res_r;

  logic [SW-1:0] sum_fin;
  logic [QW-1:0] qr;
  always_comb begin
    sum_fin = (sum_r + SW'(tf_r) + SW'(4)) >> 3;
    qr = (quo_r + QW'(1)) >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BK_IDLE;
    else st_r <= st_nxt;
    case (st_r)
      BK_IDLE: begin c_r <= q_data; tri_r <= 3'd0; sum_r <= '0; tf_r <= '0; end
      BK_SEL: begin
        // fold in the previous triangle; a split triangle gets its share from the divider
        sum_r <= sum_r + SW'(tf_r);
        tf_r <= (cnt == 2'd3) ? One : '0;
        if ((cnt == 2'd3 || cnt == 2'd0) && tri_r != 3'd7) begin
          tri_r <= tri_r + 3'd1;
        end
        if ((cnt == 2'd1) == pa) begin v_r <= ta; p_r <= tb; q_r <= tc; end
        else if ((cnt == 2'd1) == pb) begin v_r <= tb; p_r <= ta; q_r <= tc; end
        else begin v_r <= tc; p_r <= ta; q_r <= tb; end
      end
      BK_MUL: begin
        vpos_r <= v_r > 0;
        n_r <= mv * mv;
        d_r <= mvp * mvq;
        rem_r <= mv * mv;
        quo_r <= '0;
        it_r <= ($clog2(FRAC_BITS+2))'(FRAC_BITS + 1);
      end
      BK_DIV: begin
        if (d_r == '0) tf_r <= '0;
        else if (n_r >= d_r) tf_r <= vpos_r ? One : '0;
        else if (it_r != '0) begin
          if (rsh >= {1'b0, d_r}) begin
            rem_r <= (2*MW)'(rsh - {1'b0, d_r});
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rsh[2*MW-1:0];
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          it_r <= it_r - 1'b1;
        end else tf_r <= vpos_r ? qr : One - qr;
      end
      BK_ACC: begin
        if (tri_r == 3'd7) begin
          res_r <= (sum_fin > SW'(One)) ? OutW'(One) : OutW'(sum_fin);
        end else begin
          sum_r <= sum_r + SW'(tf_r);
          tf_r <= '0;
          tri_r <= tri_r + 3'd1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/grounded_cell_fraction_stencil_unit.sv @@
// Grounded cell fraction stencil unit, top level; uses gcfs_pkg, gcfs_front, gcfs_queue, gcfs_back.
// The back end takes one cell per pass, whose length is set by the shared serial divider
// for each split triangle, and takes no new cell until its result is taken; columns with
// no result do not reach the queue.
// Synchronous active-low reset clears window, count, queue and FSM; ratio = 58368.
`default_nettype none
module grounded_cell_fraction_stencil_unit
  import gcfs_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
)(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [RatioW-1:0]       cfg_density_ratio,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [ElevW-1:0] in_sea_north,
  input  wire logic signed [ElevW-1:0] in_bed_north,
  input  wire logic [ThickW-1:0]       in_thick_north,
  input  wire logic signed [ElevW-1:0] in_sea_mid,
  input  wire logic signed [ElevW-1:0] in_bed_mid,
  input  wire logic [ThickW-1:0]       in_thick_mid,
  input  wire logic signed [ElevW-1:0] in_sea_south,
  input  wire logic signed [ElevW-1:0] in_bed_south,
  input  wire logic [ThickW-1:0]       in_thick_south,
  input  wire logic                    in_row_start,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [OutW-1:0]              out_fraction
);
  logic [RatioW-1:0] ratio_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) ratio_r <= RatioReset;
    else if (cfg_valid) ratio_r <= cfg_density_ratio;
  end

  logic  fv, fr, qv, qt;
  cell_t fd, qd;

  gcfs_front u_front (
    .clk, .rst_n, .ratio(ratio_r), .in_valid, .in_stall,
    .sea_n(in_sea_north), .bed_n(in_bed_north), .th_n(in_thick_north),
    .sea_m(in_sea_mid), .bed_m(in_bed_mid), .th_m(in_thick_mid),
    .sea_s(in_sea_south), .bed_s(in_bed_south), .th_s(in_thick_south),
    .row_start(in_row_start), .c_valid(fv), .c_ready(fr), .c_data(fd)
  );
  gcfs_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
    .rd_valid(qv), .rd_take(qt), .rd_data(qd)
  );
  gcfs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid(qv), .q_take(qt), .q_data(qd),
    .out_valid, .out_stall, .out_fraction
  );
endmodule
`default_nettype wire
